// ===== src/asm_pkg.sv =====
// Shared types, constants and helper functions for the smoothed acceleration
// magnitude block. No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package asm_pkg;

  localparam int unsigned AxisW   = 8;   // raw sample and smoothed value width
  localparam int unsigned MagW    = 7;   // magnitude bits that carry a weight
  localparam int unsigned MgW     = 12;  // milli-g accumulator, at most 2267
  localparam int unsigned SqW     = 2 * AxisW;
  localparam int unsigned SumW    = 18;  // sum of three squares, at most 153228
  localparam int unsigned RootW   = 9;   // floor square root, at most 391
  localparam int unsigned RemW    = RootW + 1;
  localparam int unsigned ProdW   = MgW + 11;
  localparam int unsigned CntW    = 3;
  localparam int unsigned SqCntW  = 4;

  // floor(v / 10) is floor(v * 1639 / 2^14) for every v below 2268.
  localparam logic [10:0] DivTenMul   = 11'd1639;
  localparam int unsigned DivTenShift = 14;

  localparam logic [CntW-1:0] LastBit  = CntW'(MagW - 1);
  localparam logic [CntW-1:0] LastAxis = CntW'(2);
  localparam logic [SqCntW-1:0] SqrtSteps = SqCntW'(RootW);

  typedef struct packed {
    logic [AxisW-1:0] x_raw;
    logic [AxisW-1:0] y_raw;
    logic [AxisW-1:0] z_raw;
  } in_item_t;

  typedef struct packed {
    logic [AxisW-1:0] x_filtered;
    logic [AxisW-1:0] y_filtered;
    logic [AxisW-1:0] z_filtered;
    logic [RootW-1:0] net_magnitude;
  } out_item_t;

  // Sequencing commands shared by the three axis units.
  typedef struct packed {
    logic            load;
    logic            step;
    logic [CntW-1:0] bit_idx;
    logic            div;
    logic            smooth;
  } axis_ctrl_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StDiv,
    StSmooth,
    StSquare,
    StRootStart,
    StRoot,
    StFinish
  } core_state_e;

  // Milli-g weight of one magnitude bit; bit 7 carries none.
  function automatic logic [MgW-1:0] mg_weight(input logic [CntW-1:0] idx);
    logic [MgW-1:0] w;
    unique case (idx)
      3'd0:    w = 12'd18;
      3'd1:    w = 12'd36;
      3'd2:    w = 12'd71;
      3'd3:    w = 12'd143;
      3'd4:    w = 12'd286;
      3'd5:    w = 12'd571;
      3'd6:    w = 12'd1142;
      default: w = 12'd0;
    endcase
    return w;
  endfunction

  // floor(v / 10) for v below 2268, by reciprocal multiplication.
  function automatic logic [AxisW-1:0] div_ten(input logic [MgW-1:0] v);
    logic [ProdW-1:0] prod;
    prod = ProdW'(v) * ProdW'(DivTenMul);
    return prod[DivTenShift +: AxisW];
  endfunction

endpackage

// ===== src/asm_axis.sv =====
// One axis: absolute value, bit-serial milli-g weighting, scaling to centi-g
// and exponential smoothing with the kept value. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_axis (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  asm_pkg::axis_ctrl_t      ctrl_i,
  input  logic [asm_pkg::AxisW-1:0] raw_i,
  output logic [asm_pkg::AxisW-1:0] smoothed_o
);

  logic [asm_pkg::AxisW-1:0] abs_val;
  logic [asm_pkg::MagW-1:0]  mag_q, mag_d;
  logic [asm_pkg::MgW-1:0]   acc_q, acc_d;
  logic [asm_pkg::AxisW-1:0] centi_q;
  logic [asm_pkg::AxisW-1:0] smoothed_q;
  logic [asm_pkg::MgW-1:0]   blend;

  // The most negative sample negates to itself and so has no weighted bits.
  assign abs_val = raw_i[asm_pkg::AxisW-1] ? (~raw_i + asm_pkg::AxisW'(1)) : raw_i;

  assign blend = asm_pkg::MgW'({centi_q, 1'b0}) + asm_pkg::MgW'({smoothed_q, 3'b000});

  always_comb begin
    mag_d = mag_q;
    acc_d = acc_q;
    if (ctrl_i.load) begin
      mag_d = abs_val[asm_pkg::MagW-1:0];
      acc_d = '0;
    end else if (ctrl_i.step) begin
      mag_d = mag_q >> 1;
      if (mag_q[0]) begin
        acc_d = acc_q + asm_pkg::mg_weight(ctrl_i.bit_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    acc_q <= acc_d;
    if (ctrl_i.div) begin
      centi_q <= asm_pkg::div_ten(acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_q <= '0;
    end else if (ctrl_i.smooth) begin
      smoothed_q <= asm_pkg::div_ten(blend);
    end
  end

  assign smoothed_o = smoothed_q;

endmodule

// ===== src/asm_sqrt.sv =====
// Restoring digit-by-digit square root: two radicand bits in, one root bit
// out per cycle. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [asm_pkg::SumW-1:0]  radicand_i,
  output logic                      idle_o,
  output logic [asm_pkg::RootW-1:0] root_o
);

  logic [asm_pkg::SumW-1:0]   rad_q, rad_d;
  logic [asm_pkg::RemW-1:0]   rem_q, rem_d;
  logic [asm_pkg::RootW-1:0]  root_q, root_d;
  logic [asm_pkg::SqCntW-1:0] cnt_q, cnt_d;
  logic [asm_pkg::RemW+1:0]   rem_sh;
  logic [asm_pkg::RemW+1:0]   trial;

  assign rem_sh = {rem_q, rad_q[asm_pkg::SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = asm_pkg::SqrtSteps;
    end else if (cnt_q != '0) begin
      rad_d = rad_q << 2;
      cnt_d = cnt_q - asm_pkg::SqCntW'(1);
      if (rem_sh >= trial) begin
        rem_d  = asm_pkg::RemW'(rem_sh - trial);
        root_d = {root_q[asm_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[asm_pkg::RemW-1:0];
        root_d = {root_q[asm_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign idle_o = (cnt_q == '0);
  assign root_o = root_q;

endmodule

// ===== src/accel_smooth_magnitude_core.sv =====
// Top level of the smoothed acceleration magnitude block: sequencer, three
// axis units, sum of squares and square root. Depends on asm_pkg, asm_axis
// and asm_sqrt.
//
//   Channel  Valid        Ready        Payload
//   input    in_valid_i   in_ready_o   in_data_i  (asm_pkg::in_item_t)
//   output   out_valid_o  out_ready_i  out_data_o (asm_pkg::out_item_t)
//
// After the input transfer an item passes through 7 weighting steps, scaling,
// smoothing, a square-accumulate of each axis, a root start, 9 root steps, a
// check that the root has finished and the output load.
// Reset clears the smoothed values to zero and empties the output register.
// A new item is taken while the previous result still waits; its result is
// held back until the output register is free.
`timescale 1ns / 1ps

module accel_smooth_magnitude_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  asm_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output asm_pkg::out_item_t  out_data_o
);

  asm_pkg::core_state_e state_q, state_d;
  logic [asm_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [asm_pkg::SumW-1:0]  sum_q;
  logic [asm_pkg::AxisW-1:0] x_s, y_s, z_s;
  logic [asm_pkg::AxisW-1:0] sq_sel;
  logic [asm_pkg::SqW-1:0]   sq_val;
  logic [asm_pkg::RootW-1:0] root;
  logic                      root_idle;
  logic                      in_xfer;
  logic                      out_load;
  logic                      root_start;
  logic                      out_valid_q;
  asm_pkg::out_item_t        out_q;
  asm_pkg::axis_ctrl_t       axis_ctrl;

  assign in_xfer = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asm_pkg::StIdle:      if (in_valid_i) state_d = asm_pkg::StConv;
      asm_pkg::StConv:      if (cnt_q == asm_pkg::LastBit) state_d = asm_pkg::StDiv;
      asm_pkg::StDiv:       state_d = asm_pkg::StSmooth;
      asm_pkg::StSmooth:    state_d = asm_pkg::StSquare;
      asm_pkg::StSquare:    if (cnt_q == asm_pkg::LastAxis) state_d = asm_pkg::StRootStart;
      asm_pkg::StRootStart: state_d = asm_pkg::StRoot;
      asm_pkg::StRoot:      if (root_idle) state_d = asm_pkg::StFinish;
      asm_pkg::StFinish:    if (!out_valid_q || out_ready_i) state_d = asm_pkg::StIdle;
      default:              state_d = asm_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o        = 1'b0;
    axis_ctrl.load    = 1'b0;
    axis_ctrl.step    = 1'b0;
    axis_ctrl.bit_idx = cnt_q;
    axis_ctrl.div     = 1'b0;
    axis_ctrl.smooth  = 1'b0;
    root_start        = 1'b0;
    out_load          = 1'b0;
    unique case (state_q)
      asm_pkg::StIdle: begin
        in_ready_o     = 1'b1;
        axis_ctrl.load = in_valid_i;
      end
      asm_pkg::StConv:      axis_ctrl.step   = 1'b1;
      asm_pkg::StDiv:       axis_ctrl.div    = 1'b1;
      asm_pkg::StSmooth:    axis_ctrl.smooth = 1'b1;
      asm_pkg::StSquare:    ;
      asm_pkg::StRootStart: root_start = 1'b1;
      asm_pkg::StRoot:      ;
      asm_pkg::StFinish:    out_load = !out_valid_q || out_ready_i;
      default:              ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == asm_pkg::StConv || state_q == asm_pkg::StSquare) begin
      cnt_d = (state_d == state_q) ? cnt_q + asm_pkg::CntW'(1) : '0;
    end else begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asm_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  asm_axis u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (axis_ctrl),
    .raw_i      (in_data_i.x_raw),
    .smoothed_o (x_s)
  );

  asm_axis u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (axis_ctrl),
    .raw_i      (in_data_i.y_raw),
    .smoothed_o (y_s)
  );

  asm_axis u_axis_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (axis_ctrl),
    .raw_i      (in_data_i.z_raw),
    .smoothed_o (z_s)
  );

  // One axis is squared and accumulated per cycle.
  always_comb begin
    unique case (cnt_q)
      3'd0:    sq_sel = x_s;
      3'd1:    sq_sel = y_s;
      default: sq_sel = z_s;
    endcase
  end

  assign sq_val = sq_sel * sq_sel;

  always_ff @(posedge clk_i) begin
    if (state_q == asm_pkg::StSmooth) begin
      sum_q <= '0;
    end else if (state_q == asm_pkg::StSquare) begin
      sum_q <= sum_q + asm_pkg::SumW'(sq_val);
    end
  end

  asm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_q),
    .idle_o     (root_idle),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.x_filtered    <= x_s;
      out_q.y_filtered    <= y_s;
      out_q.z_filtered    <= z_s;
      out_q.net_magnitude <= root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/asm_checker.sv =====
// Port-level checks for the smoothed acceleration magnitude block, bound to
// the top level. Depends on asm_pkg and accel_smooth_magnitude_core.
`timescale 1ns / 1ps

module asm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input asm_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input asm_pkg::out_item_t out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A waiting input transfer keeps its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // Only one item is in work at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // A result cannot appear right after a transfer.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result too early");

  // The vector magnitude is never below any of its components.
  a_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (9'(out_data_o.x_filtered) <= out_data_o.net_magnitude)
                 && (9'(out_data_o.y_filtered) <= out_data_o.net_magnitude)
                 && (9'(out_data_o.z_filtered) <= out_data_o.net_magnitude))
    else $error("magnitude below a component");

endmodule

bind accel_smooth_magnitude_core asm_checker u_asm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for accel_smooth_magnitude_core: random and directed
// accelerometer samples with a bit-exact predictor of the smoothed axes and their
// magnitude. Depends on asm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned HoldCycles  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  asm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  asm_pkg::out_item_t out_data;

  asm_pkg::in_item_t  samples_to_send[$];
  asm_pkg::out_item_t expected_readings[$];

  logic [asm_pkg::AxisW-1:0] smoothed_x = '0;
  logic [asm_pkg::AxisW-1:0] smoothed_y = '0;
  logic [asm_pkg::AxisW-1:0] smoothed_z = '0;

  int unsigned n_items = 0;
  int unsigned n_accepted = 0;
  int unsigned n_received = 0;
  int unsigned n_errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  logic        hold_off = 1'b0;

  accel_smooth_magnitude_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Milli-g weight of one magnitude bit.
  function automatic int unsigned weight_mg(int unsigned b);
    case (b)
      0: return 18;
      1: return 36;
      2: return 71;
      3: return 143;
      4: return 286;
      5: return 571;
      6: return 1142;
      default: return 0;
    endcase
  endfunction

  // Absolute value, weighted bit sum in milli-g, then down to centi-g.
  function automatic int unsigned centi_g(logic [asm_pkg::AxisW-1:0] raw);
    logic [asm_pkg::AxisW-1:0] mag;
    int unsigned mg;
    mag = raw[asm_pkg::AxisW-1] ? (~raw + 8'd1) : raw;
    mg = 0;
    for (int b = 0; b < 7; b++) begin
      if (mag[b]) mg += weight_mg(b);
    end
    return mg / 10;
  endfunction

  function automatic logic [asm_pkg::AxisW-1:0] blend(int unsigned fresh,
                                                      logic [asm_pkg::AxisW-1:0] old);
    return asm_pkg::AxisW'((2 * fresh + 8 * int'(old)) / 10);
  endfunction

  function automatic logic [asm_pkg::RootW-1:0] floor_sqrt(logic [asm_pkg::SumW-1:0] n);
    logic [asm_pkg::RootW-1:0] root;
    logic [asm_pkg::RootW-1:0] trial;
    int unsigned t;
    root = '0;
    for (int b = asm_pkg::RootW - 1; b >= 0; b--) begin
      trial = root | (9'd1 << b);
      t = trial;
      if (t * t <= n) root = trial;
    end
    return root;
  endfunction

  // Advances the smoothing state by one sample and returns the expected reading.
  function automatic asm_pkg::out_item_t smooth_and_measure(asm_pkg::in_item_t s);
    asm_pkg::out_item_t r;
    int unsigned sum;
    smoothed_x = blend(centi_g(s.x_raw), smoothed_x);
    smoothed_y = blend(centi_g(s.y_raw), smoothed_y);
    smoothed_z = blend(centi_g(s.z_raw), smoothed_z);
    sum = smoothed_x * smoothed_x + smoothed_y * smoothed_y + smoothed_z * smoothed_z;
    r.x_filtered    = smoothed_x;
    r.y_filtered    = smoothed_y;
    r.z_filtered    = smoothed_z;
    r.net_magnitude = floor_sqrt(asm_pkg::SumW'(sum));
    return r;
  endfunction

  // Mostly short pauses, a few long ones, and whole stretches with none at all.
  function automatic int unsigned idle_cycles(int unsigned progress);
    int unsigned r;
    if ((progress / 128) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [asm_pkg::AxisW-1:0] wobble(logic [asm_pkg::AxisW-1:0] base);
    return asm_pkg::AxisW'(int'(base) + int'($urandom_range(0, 6)) - 3);
  endfunction

  function automatic logic [asm_pkg::AxisW-1:0] extreme_sample();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'h81;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic queue_sample(logic [asm_pkg::AxisW-1:0] x, logic [asm_pkg::AxisW-1:0] y,
                              logic [asm_pkg::AxisW-1:0] z);
    asm_pkg::in_item_t s;
    s.x_raw = x;
    s.y_raw = y;
    s.z_raw = z;
    samples_to_send.push_back(s);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Sender: offers queued samples, with random gaps between transfers.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_ready)) begin
      if (in_valid) begin
        expected_readings.push_back(smooth_and_measure(in_data));
        n_accepted++;
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (samples_to_send.size() != 0) begin
        in_data  <= samples_to_send.pop_front();
        in_valid <= 1'b1;
        gap_left <= idle_cycles(n_accepted);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          n_errors++;
        end else begin
          asm_pkg::out_item_t e;
          e = expected_readings.pop_front();
          check_field("x_filtered", e.x_filtered, out_data.x_filtered);
          check_field("y_filtered", e.y_filtered, out_data.y_filtered);
          check_field("z_filtered", e.z_filtered, out_data.z_filtered);
          check_field("net_magnitude", e.net_magnitude, out_data.net_magnitude);
        end
        n_received++;
      end
      if (hold_off || stall_left != 0) begin
        out_ready <= 1'b0;
        if (stall_left != 0) stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) begin
          stall_left <= idle_cycles(n_received);
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left <= idle_cycles(n_received);
        end
      end
    end
  end

  // One long hold-off on the output so that the block backs up into its input.
  initial begin
    wait (n_accepted >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [asm_pkg::AxisW-1:0] bx, by, bz;
    int unsigned run;
    int unsigned kind;

    // Directed: zero, full scale both ways, the most negative sample, single bits.
    queue_sample(8'h00, 8'h00, 8'h00);
    queue_sample(8'h7F, 8'h7F, 8'h7F);
    queue_sample(8'h80, 8'h80, 8'h80);
    queue_sample(8'h81, 8'h81, 8'h81);
    queue_sample(8'hFF, 8'h01, 8'h80);
    queue_sample(8'h01, 8'hFF, 8'h7F);
    queue_sample(8'h02, 8'h04, 8'h08);
    queue_sample(8'h10, 8'h20, 8'h40);
    queue_sample(8'hFE, 8'hFC, 8'hF8);
    queue_sample(8'hF0, 8'hE0, 8'hC0);
    // Drive the smoothed values towards their ceiling, then let them decay.
    repeat (10) queue_sample(8'h7F, 8'h81, 8'h7F);
    repeat (5) queue_sample(8'h80, 8'h00, 8'h80);

    while (samples_to_send.size() < 25 + RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // A held orientation with a little sensor noise.
        bx  = asm_pkg::AxisW'($urandom);
        by  = asm_pkg::AxisW'($urandom);
        bz  = asm_pkg::AxisW'($urandom);
        run = $urandom_range(4, 20);
        repeat (run) queue_sample(wobble(bx), wobble(by), wobble(bz));
      end else if (kind < 8) begin
        queue_sample(asm_pkg::AxisW'($urandom), asm_pkg::AxisW'($urandom),
                     asm_pkg::AxisW'($urandom));
      end else begin
        queue_sample(extreme_sample(), extreme_sample(), extreme_sample());
      end
    end
    n_items = samples_to_send.size();

    wait (rst_n && n_accepted == n_items);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/asm_pkg.sv
src/asm_axis.sv
src/asm_sqrt.sv
src/accel_smooth_magnitude_core.sv
src/asm_checker.sv
tb/tb.sv
